/* rtl/ssipa_pkg.sv */
package ssipa_pkg;

	// Item kinds carried on the input tuser
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam int SSIPA_TABLE_SLOTS = 256;
	localparam int NUM_COUNTS        = 9;
	localparam int ADDR_W            = 29;
	localparam int COUNT_W           = 8;
	localparam int SUM_W             = 64;
	localparam int IDX_W             = 8;
	localparam int DROP_BIT          = 8;
	localparam int IN_DATA_W         = 128;
	localparam int OUT_USER_W        = 3;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [1:0]                       kind;
		logic [ADDR_W-1:0]                addr;
		logic [NUM_COUNTS*COUNT_W-1:0]    counts;
		logic                             drop;
		logic [IDX_W-1:0]                 idx;
	} item_t;

	// Readout order of the sums: active, control, pipe, send, distance,
	// scoreboard, sync, fetch, other
	function automatic logic [3:0] read_order(input logic [3:0] k);
		logic [3:0] r;
		case (k)
			4'd0: r = 4'd0;
			4'd1: r = 4'd2;
			4'd2: r = 4'd3;
			4'd3: r = 4'd4;
			4'd4: r = 4'd5;
			4'd5: r = 4'd6;
			4'd6: r = 4'd7;
			4'd7: r = 4'd8;
			4'd8: r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/stall_sample_ip_accumulator.sv */
// Channel  Dir  tdata                                              tuser / tlast
// s_*      in   record_low, record_high, status_flags, read_index  tuser: kind
// m_*      out  value                                              tlast: last;
//                                                                  tuser: overflow_drop,
//                                                                  table_full, entry_valid
// A sample is popped, then searches the filled slots in turn (address store read, then
// compare), checks for the end of the search, does the nine read-modify-writes of the
// sum store and emits the result; a full table skips the sums.
// A read of a filled slot emits the address and then each sum through the single sum store read port;
// a clear finishes at the pop.
// Reset clears the fill count but not the stores: slots below the count are valid, so no clearing pass.
// A two-deep queue takes input while the back end works; the output register stalls the back.
module stall_sample_ip_accumulator
	import ssipa_pkg::*;
#(
	parameter int TABLE_SLOTS = SSIPA_TABLE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [63:0] record_low, [100:64] record_high, [116:101] status_flags,
	// [124:117] read_index, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [63:0] value
	output logic [SUM_W-1:0]      m_tdata,
	output logic                  m_tlast,
	// [0] overflow_drop, [1] table_full, [2] entry_valid
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	ssipa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ssipa_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/ssipa_front.sv */
module ssipa_front
	import ssipa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	item_t      cls;
	logic [100:0] rec;
	logic       known;

	// Classify: pull address, counts and drop bit out of the raw record
	assign rec         = s_tdata[100:0];
	assign cls.kind    = s_tuser;
	assign cls.addr    = rec[ADDR_W-1:0];
	assign cls.counts  = rec[100:ADDR_W];
	assign cls.drop    = s_tdata[101 + DROP_BIT];
	assign cls.idx     = s_tdata[124:117];
	assign known       = (s_tuser == KIND_SAMPLE) || (s_tuser == KIND_READ) ||
	                     (s_tuser == KIND_CLEAR);

	assign s_tready = (fill_q != 2'd2);
	// Drop unused kinds at the door
	assign push     = s_tvalid && s_tready && known;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/ssipa_back.sv */
module ssipa_back
	import ssipa_pkg::*;
#(
	parameter int TABLE_SLOTS = SSIPA_TABLE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SUM_W-1:0]      m_tdata,
	output logic                  m_tlast,
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int SUM_AW = $clog2(TABLE_SLOTS * NUM_COUNTS);
	localparam int SUM_D  = TABLE_SLOTS * NUM_COUNTS;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN     = 4'd1;
	localparam logic [3:0] ST_CMP      = 4'd2;
	localparam logic [3:0] ST_ACC_RD   = 4'd3;
	localparam logic [3:0] ST_ACC_WR   = 4'd4;
	localparam logic [3:0] ST_EMIT     = 4'd5;
	localparam logic [3:0] ST_RD_ADDR  = 4'd6;
	localparam logic [3:0] ST_RD_HEAD  = 4'd7;
	localparam logic [3:0] ST_SUM_RD   = 4'd8;
	localparam logic [3:0] ST_SUM_EMIT = 4'd9;

	logic [ADDR_W-1:0] addr_mem [TABLE_SLOTS];
	logic [SUM_W-1:0]  sum_mem [SUM_D];

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  scan_q;
	logic [SLOT_W-1:0] slot_q;
	logic [3:0]        k_q;
	logic              alloc_q;
	item_t             item_q;
	logic              res_full_q;
	logic              res_valid_q;
	logic              res_drop_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [ADDR_W-1:0] addr_rd_q;
	logic [SUM_W-1:0]  sum_rd_q;

	logic              out_free;
	logic              out_load;
	logic [SUM_W-1:0]  out_data;
	logic              out_last;
	logic [OUT_USER_W-1:0] out_user;
	logic              addr_re;
	logic              addr_we;
	logic [SLOT_W-1:0] addr_ra;
	logic              sum_re;
	logic              sum_we;
	logic [SUM_AW-1:0] sum_ra;
	logic [SUM_AW-1:0] sum_wa;
	logic [SUM_W-1:0]  sum_wd;
	logic              rd_hit;
	logic [SUM_AW-1:0] slot_base;
	logic [COUNT_W-1:0] cur_count;

	assign out_free  = !m_tvalid || m_tready;
	assign rd_hit    = ({{CNT_W{1'b0}}, q_item.idx}) < ({{IDX_W{1'b0}}, used_q});
	assign slot_base = SUM_AW'({slot_q, 3'b000}) + SUM_AW'(slot_q);
	assign cur_count = item_q.counts[k_q*COUNT_W +: COUNT_W];
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// Memory port control and result selection
	always_comb begin
		addr_re  = 1'b0;
		addr_we  = 1'b0;
		addr_ra  = scan_q[SLOT_W-1:0];
		sum_re   = 1'b0;
		sum_we   = 1'b0;
		sum_ra   = slot_base + SUM_AW'(k_q);
		sum_wa   = slot_base + SUM_AW'(k_q);
		sum_wd   = (alloc_q ? '0 : sum_rd_q) + SUM_W'(cur_count);
		out_load = 1'b0;
		out_data = '0;
		out_last = 1'b0;
		out_user = '0;
		case (state_q)
			ST_SCAN: begin
				if (scan_q == used_q) begin
					addr_we = (used_q != CNT_W'(TABLE_SLOTS));
				end else begin
					addr_re = 1'b1;
				end
			end
			ST_ACC_RD: sum_re = 1'b1;
			ST_ACC_WR: sum_we = 1'b1;
			ST_EMIT: begin
				out_load = out_free;
				out_data = SUM_W'(res_addr_q);
				out_last = 1'b1;
				out_user = {res_valid_q, res_full_q, res_drop_q};
			end
			ST_RD_ADDR: begin
				addr_re = 1'b1;
				addr_ra = slot_q;
			end
			ST_RD_HEAD: begin
				out_load = out_free;
				out_data = SUM_W'(addr_rd_q);
				out_user = 3'b100;
			end
			ST_SUM_RD: begin
				sum_re = 1'b1;
				sum_ra = slot_base + SUM_AW'(read_order(k_q));
			end
			ST_SUM_EMIT: begin
				out_load = out_free;
				out_data = sum_rd_q;
				out_last = (k_q == 4'(NUM_COUNTS - 1));
				out_user = 3'b100;
			end
			default: ;
		endcase
	end

	// Address store: allocation writes the next free slot
	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[used_q[SLOT_W-1:0]] <= item_q.addr;
		end
		if (addr_re) begin
			addr_rd_q <= addr_mem[addr_ra];
		end
	end

	// Sum store: one read-modify-write per count
	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_ra];
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_SCAN && scan_q == used_q) begin
			res_addr_q  <= item_q.addr;
			res_drop_q  <= item_q.drop;
			res_full_q  <= (used_q == CNT_W'(TABLE_SLOTS));
			res_valid_q <= (used_q != CNT_W'(TABLE_SLOTS));
		end else if (state_q == ST_CMP) begin
			res_addr_q  <= item_q.addr;
			res_drop_q  <= item_q.drop;
			res_full_q  <= 1'b0;
			res_valid_q <= 1'b1;
		end else if (q_pop) begin
			res_addr_q  <= '0;
			res_drop_q  <= 1'b0;
			res_full_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end
		if (out_load) begin
			m_tdata <= out_data;
			m_tlast <= out_last;
			m_tuser <= out_user;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			scan_q   <= '0;
			slot_q   <= '0;
			k_q      <= '0;
			alloc_q  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						scan_q <= '0;
						k_q    <= '0;
						case (q_item.kind)
							KIND_SAMPLE: state_q <= ST_SCAN;
							KIND_READ: begin
								state_q <= rd_hit ? ST_RD_ADDR : ST_EMIT;
								slot_q  <= SLOT_W'({{CNT_W{1'b0}}, q_item.idx});
							end
							default: used_q <= '0;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_q == used_q) begin
						if (used_q == CNT_W'(TABLE_SLOTS)) begin
							state_q <= ST_EMIT;
						end else begin
							slot_q  <= used_q[SLOT_W-1:0];
							used_q  <= used_q + CNT_W'(1);
							alloc_q <= 1'b1;
							state_q <= ST_ACC_RD;
						end
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (addr_rd_q == item_q.addr) begin
						slot_q  <= scan_q[SLOT_W-1:0];
						alloc_q <= 1'b0;
						state_q <= ST_ACC_RD;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: begin
					if (k_q == 4'(NUM_COUNTS - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ST_ACC_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ADDR: state_q <= ST_RD_HEAD;
				ST_RD_HEAD: begin
					if (out_free) begin
						state_q <= ST_SUM_RD;
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_EMIT;
				ST_SUM_EMIT: begin
					if (out_free) begin
						if (k_q == 4'(NUM_COUNTS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= ST_SUM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The fill count never passes the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_SLOTS))
		else $error("slot fill count beyond table size");

	// The search never runs past the filled slots
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_CMP) |-> scan_q <= used_q)
		else $error("tag search beyond filled slots");

	// A clear empties the table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.kind == KIND_CLEAR) |=> used_q == '0)
		else $error("clear left slots in use");

	// Read readout for an unused slot never emits sums
	a_read_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_HEAD) |-> ({{CNT_W{1'b0}}, item_q.idx}) <
		({{IDX_W{1'b0}}, used_q}))
		else $error("readout of an empty slot");

	// Sum index stays inside the count set
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q < 4'(NUM_COUNTS))
		else $error("count index out of range");

endmodule

/* tb/stall_sample_ip_accumulator_checker.sv */
module stall_sample_ip_accumulator_checker
	import ssipa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [SUM_W-1:0]      m_tdata,
	input  logic                  m_tlast,
	input  logic [OUT_USER_W-1:0] m_tuser,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen
);

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             last;
		logic             drop;
		logic             full;
		logic             valid;
	} beat_t;

	beat_t                   awaited_beats[$];
	logic                    slot_live[SSIPA_TABLE_SLOTS];
	logic [ADDR_W-1:0]       slot_tag[SSIPA_TABLE_SLOTS];
	logic [SUM_W-1:0]        slot_sum[SSIPA_TABLE_SLOTS][NUM_COUNTS];
	int                      fill_level;

	assign pending = awaited_beats.size();

	// Append one awaited result transfer
	task automatic queue_beat(input beat_t b);
		awaited_beats.insert(awaited_beats.size(), b);
	endtask

	// Accumulate one sample into the table shadow and queue its reply
	task automatic accumulate_sample(input logic [100:0] rec, input logic drop);
		logic [ADDR_W-1:0] addr;
		int                s;
		bit                hit;
		beat_t             b;
		addr = rec[ADDR_W-1:0];
		hit  = 0;
		for (s = 0; s < fill_level; s++)
			if (slot_live[s] && slot_tag[s] == addr) begin
				hit = 1;
				break;
			end
		b = '{value: SUM_W'(addr), last: 1'b1, drop: drop, full: 1'b0, valid: 1'b1};
		if (!hit && fill_level >= SSIPA_TABLE_SLOTS) begin
			b.full  = 1'b1;
			b.valid = 1'b0;
		end else begin
			if (!hit) begin
				s = fill_level;
				fill_level++;
				slot_live[s] = 1'b1;
				slot_tag[s]  = addr;
				for (int k = 0; k < NUM_COUNTS; k++)
					slot_sum[s][k] = '0;
			end
			for (int k = 0; k < NUM_COUNTS; k++)
				slot_sum[s][k] += SUM_W'(rec[ADDR_W + COUNT_W*k +: COUNT_W]);
		end
		queue_beat(b);
	endtask

	// Queue the readout of one slot
	task automatic read_slot(input logic [IDX_W-1:0] idx);
		int order[NUM_COUNTS] = '{0, 2, 3, 4, 5, 6, 7, 8, 1};
		if (!slot_live[idx]) begin
			queue_beat('{value: '0, last: 1'b1, drop: 1'b0, full: 1'b0, valid: 1'b0});
		end else begin
			queue_beat('{value: SUM_W'(slot_tag[idx]), last: 1'b0, drop: 1'b0,
				full: 1'b0, valid: 1'b1});
			for (int k = 0; k < NUM_COUNTS; k++)
				queue_beat('{value: slot_sum[idx][order[k]],
					last: (k == NUM_COUNTS - 1), drop: 1'b0, full: 1'b0, valid: 1'b1});
		end
	endtask

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			fill_level    = 0;
			fail_count   <= 0;
			results_seen <= 0;
			for (int s = 0; s < SSIPA_TABLE_SLOTS; s++)
				slot_live[s] = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					KIND_SAMPLE: accumulate_sample(s_tdata[100:0], s_tdata[101 + DROP_BIT]);
					KIND_READ:   read_slot(s_tdata[124:117]);
					KIND_CLEAR: begin
						for (int s = 0; s < SSIPA_TABLE_SLOTS; s++)
							slot_live[s] = 1'b0;
						fill_level = 0;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (awaited_beats.size() == 0) begin
					$display("%0t: unexpected transfer value=%h last=%b user=%b", $time,
						m_tdata, m_tlast, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_beats.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last ||
						m_tuser !== {want.valid, want.full, want.drop}) begin
						$display("%0t: mismatch expected value=%h last=%b user=%b",
							$time, want.value, want.last, {want.valid, want.full, want.drop});
						$display("%0t:          actual   value=%h last=%b user=%b",
							$time, m_tdata, m_tlast, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/stall_sample_ip_accumulator_test.sv */
module stall_sample_ip_accumulator_test;
	import ssipa_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [SUM_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic [OUT_USER_W-1:0] m_tuser;
	int                    fail_count;
	int                    pending;
	int                    results_seen;
	int                    cycle_count;
	int                    items_sent;
	bit                    calm_stretch;
	logic [ADDR_W-1:0]     addr_pool[8];

	localparam int CYCLE_LIMIT = 2_000_000;

	stall_sample_ip_accumulator uut (.*);

	stall_sample_ip_accumulator_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Random stalls on the output side
	always @(posedge clk or negedge arst_n)
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm_stretch || $urandom_range(99) >= 16;

	// Present one item and hold it until the transfer; idle cycles drop tvalid
	task automatic send_item(input logic [1:0] kind, input logic [100:0] rec,
		input logic [15:0] flags, input logic [7:0] idx);
		while (!calm_stretch && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, idx, flags, rec};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic [100:0] random_record();
		return 101'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	task automatic send_sample(input logic [ADDR_W-1:0] addr);
		logic [100:0] rec;
		rec = random_record();
		rec[ADDR_W-1:0] = addr;
		send_item(KIND_SAMPLE, rec, 16'($urandom), 8'($urandom));
	endtask

	initial begin
		int           r;
		cycle_count  = 0;
		items_sent   = 0;
		calm_stretch = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_SAMPLE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, repeated addresses, reads of empty and valid slots
		send_item(KIND_READ, '0, '0, 8'd0);
		send_item(KIND_SAMPLE, '0, 16'h0000, 8'd0);
		send_item(KIND_SAMPLE, '1, 16'hffff, 8'hff);
		send_item(KIND_SAMPLE, '1, 16'h0100, 8'd0);
		send_item(KIND_SAMPLE, {72'h0, 29'h1fffffff}, 16'hfeff, 8'd0);
		send_item(KIND_READ, '0, 16'hffff, 8'd0);
		send_item(KIND_READ, '1, 16'h0, 8'd1);
		send_item(KIND_READ, '0, 16'h0, 8'd2);
		send_item(KIND_READ, '0, 16'h0, 8'hff);
		send_item(2'd3, '1, 16'hffff, 8'd1);
		send_item(KIND_CLEAR, '1, 16'hffff, 8'hff);
		send_item(KIND_READ, '0, 16'h0, 8'd0);
		send_item(KIND_SAMPLE, {72'h0, 29'h0abcdef}, 16'h0100, 8'd0);
		send_item(KIND_READ, '0, 16'h0, 8'd0);

		// Fill the table with one stretch free of stalls, then overflow it
		send_item(KIND_CLEAR, '0, '0, '0);
		for (int i = 0; i < SSIPA_TABLE_SLOTS; i++) begin
			calm_stretch = (i >= 100 && i < 140);
			send_sample(ADDR_W'(i * 7 + 3));
		end
		calm_stretch = 0;
		send_sample(29'h1ffffff0);
		send_sample(29'h00000003);
		send_item(KIND_READ, '0, '0, 8'hff);
		send_item(KIND_CLEAR, '0, '0, '0);

		// Random: mostly samples over a small address pool, reads of low and random slots, clears, unused kinds
		for (int i = 0; i < 8; i++)
			addr_pool[i] = ADDR_W'($urandom);
		for (int i = 0; i < 16; i++) begin
			r = $urandom_range(99);
			if (r < 60)
				send_sample($urandom_range(3) == 0 ? ADDR_W'($urandom)
					: addr_pool[$urandom_range(7)]);
			else if (r < 90)
				send_item(KIND_READ, random_record(), 16'($urandom),
					8'($urandom_range(3) == 0 ? $urandom : $urandom_range(11)));
			else if (r < 93)
				send_item(KIND_CLEAR, random_record(), 16'($urandom), 8'($urandom));
			else if (r < 96)
				send_item(2'd3, random_record(), 16'($urandom), 8'($urandom));
			else
				send_sample(addr_pool[$urandom_range(7)]);
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d items (samples, reads, clears, unused kinds, table overflow);",
			items_sent);
		$display("checked %0d result transfers under random stalls on both sides.",
			results_seen);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
